/* src/modular_exponentiation_top_macros.svh */
// Assertion macros for the modular exponentiation block.
// Used by the port checker; depends on nothing else.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// check a property on every edge outside reset
`define MEXP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define MEXP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mexp_pkg.sv */
// Shared types and constants for the modular exponentiation block.
// Used by the controller, the datapath and the top level.
package mexp_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgExponent = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgModulus  = CfgIdxW'(1);

  localparam int unsigned ExponentReset = 17;
  localparam int unsigned ModulusReset  = 2;

  // operand pair for a modular multiplication
  typedef enum logic {
    OP_ACC,   // acc * base
    OP_SQR    // base * base
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_TEST,
    S_MACC,
    S_SQST,
    S_SQR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load_item;
    logic start_mul;
    op_e  op;
    logic step;
    logic wr_acc;
    logic wr_base;
    logic next_bit;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic exp_bit;
    logic exp_last;
    logic out_busy;
  } dp_sts_t;

endpackage

/* src/mexp_ctrl.sv */
// Sequencer for square-and-multiply: steps the shared modular multiplier.
// Depends on mexp_pkg for state, command and status types.
module mexp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mexp_pkg::dp_sts_t sts_i,
  output mexp_pkg::dp_cmd_t cmd_o
);
  import mexp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.op   = OP_SQR;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_RED;
        end
      end
      // base = message mod modulus
      S_RED: begin
        cmd_o.step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.wr_base = 1'b1;
          state_d       = S_TEST;
        end
      end
      S_TEST: begin
        cmd_o.start_mul = 1'b1;
        if (sts_i.exp_bit) begin
          cmd_o.op = OP_ACC;
          state_d  = S_MACC;
        end else begin
          cmd_o.op = OP_SQR;
          state_d  = S_SQR;
        end
      end
      S_MACC: begin
        cmd_o.step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.wr_acc = 1'b1;
          state_d      = S_SQST;
        end
      end
      S_SQST: begin
        cmd_o.start_mul = 1'b1;
        cmd_o.op        = OP_SQR;
        state_d         = S_SQR;
      end
      S_SQR: begin
        cmd_o.step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.wr_base  = 1'b1;
          cmd_o.next_bit = 1'b1;
          state_d        = sts_i.exp_last ? S_DONE : S_TEST;
        end
      end
      // hold until the output register is free
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* src/mexp_dp.sv */
// Datapath: bit-serial interleaved modular multiplier, operand registers,
// exponent shifter and output register. Depends on mexp_pkg.
module mexp_dp #(
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mexp_pkg::dp_cmd_t cmd_i,
  output mexp_pkg::dp_sts_t sts_o,
  input  logic [WIDTH-1:0]  message_i,
  input  logic [WIDTH-1:0]  exponent_i,
  input  logic [WIDTH-1:0]  modulus_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WIDTH-1:0]  power_mod_o
);
  import mexp_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH);

  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] opa_q, opa_d;
  logic [WIDTH-1:0] opb_q, opb_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  bit_q, bit_d;
  logic [WIDTH-1:0] out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [WIDTH:0]   m_ext, t1, t1r, t2, t2r;
  logic [WIDTH-1:0] r_next;
  logic             mod_small;

  // one step: r = (2r + a_bit * b) mod m, with r and b below m
  always_comb begin
    m_ext  = {1'b0, modulus_i};
    t1     = {r_q, 1'b0};
    t1r    = (t1 >= m_ext) ? (t1 - m_ext) : t1;
    t2     = t1r + (opa_q[WIDTH-1] ? {1'b0, opb_q} : '0);
    t2r    = (t2 >= m_ext) ? (t2 - m_ext) : t2;
    r_next = t2r[WIDTH-1:0];
  end

  assign mod_small = (modulus_i[WIDTH-1:1] == '0);

  always_comb begin
    acc_d       = acc_q;
    base_d      = base_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    r_d         = r_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.load_item) begin
      // reduce the message by multiplying it by one
      opa_d = message_i;
      opb_d = WIDTH'(1);
      r_d   = '0;
      cnt_d = '0;
      acc_d = WIDTH'(1);
      exp_d = exponent_i;
      bit_d = '0;
    end
    if (cmd_i.start_mul) begin
      opa_d = (cmd_i.op == OP_ACC) ? acc_q : base_q;
      opb_d = base_q;
      r_d   = '0;
      cnt_d = '0;
    end
    if (cmd_i.step) begin
      r_d   = r_next;
      opa_d = {opa_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd_i.wr_acc) begin
      acc_d = r_next;
    end
    if (cmd_i.wr_base) begin
      base_d = r_next;
    end
    if (cmd_i.next_bit) begin
      exp_d = {1'b0, exp_q[WIDTH-1:1]};
      bit_d = bit_q + CntW'(1);
    end
    if (cmd_i.load_out) begin
      out_d       = mod_small ? '0 : acc_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    r_q    <= r_d;
    exp_q  <= exp_d;
    cnt_q  <= cnt_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
  end

  assign sts_o.mul_last = (cnt_q == CntW'(WIDTH - 1));
  assign sts_o.exp_bit  = exp_q[0];
  assign sts_o.exp_last = (bit_q == CntW'(WIDTH - 1));
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign power_mod_o = out_q;

endmodule

/* src/modular_exponentiation_top.sv */
// Modular exponentiation, right-to-left square-and-multiply, one word at a time.
// A single bit-serial multiplier, one bit per cycle, forms every modular product.
// A new word is taken once the previous result is in the output register.
// Reset (async, active low) loads exponent 17 and modulus 2 and idles the FSM.
module modular_exponentiation_top #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [WIDTH-1:0]             message_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [WIDTH-1:0]             power_mod_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mexp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [WIDTH-1:0]             cfg_data_i
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] exponent_q, modulus_q;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign cfg_ready_o = 1'b1;

  // drop writes to unknown registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= WIDTH'(ExponentReset);
      modulus_q  <= WIDTH'(ModulusReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgExponent) begin
        exponent_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgModulus) begin
        modulus_q <= cfg_data_i;
      end
    end
  end

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .message_i   (message_i),
    .exponent_i  (exponent_q),
    .modulus_i   (modulus_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .power_mod_o (power_mod_o)
  );

endmodule

/* src/mexp_checker.sv */
// Port checker for the modular exponentiation block, bound to the top level.
// Depends on the assertion macros header only.
`include "modular_exponentiation_top_macros.svh"

module mexp_checker #(
  parameter int unsigned WIDTH = 32
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [WIDTH-1:0] power_mod_o,
  input logic             cfg_ready_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result word holds
  property p_out_hold;
    out_valid_o && out_stall_i |=> out_valid_o && $stable(power_mod_o);
  endproperty

  // one word at a time: busy right after an accept
  property p_busy_after_accept;
    in_acc |=> in_stall_o;
  endproperty

  // no result can appear the cycle after an accept
  property p_no_instant_result;
    in_acc |=> !$rose(out_valid_o);
  endproperty

  // a fresh result frees the input side
  property p_idle_on_result;
    $rose(out_valid_o) |-> !in_stall_o;
  endproperty

  `MEXP_ASSERT(a_out_hold, clk_i, rst_ni, p_out_hold, "stalled result changed")
  `MEXP_ASSERT(a_busy_after_accept, clk_i, rst_ni, p_busy_after_accept, "input taken while busy")
  `MEXP_ASSERT(a_no_instant_result, clk_i, rst_ni, p_no_instant_result, "result too early")
  `MEXP_ASSERT(a_idle_on_result, clk_i, rst_ni, p_idle_on_result, "input not freed")
  // configuration is never back-pressured
  `MEXP_ASSERT_ALWAYS(a_cfg_ready, clk_i, !rst_ni || cfg_ready_o, "config port not ready")

endmodule

bind modular_exponentiation_top mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);

/* verif/tb.sv */
// Self-checking bench for modular_exponentiation_top: a table of directed words, then
// random key settings and messages, checked word by word against a square-and-multiply model.
// Depends on mexp_pkg and the block's RTL only.
module tb;
  import mexp_pkg::*;

  localparam int unsigned W             = 32;
  localparam int unsigned RANDOM_WORDS  = 248;
  localparam int unsigned HOLD_CYCLES   = 6000;
  localparam int unsigned TAIL_CYCLES   = 2500;
  localparam int unsigned CYCLE_LIMIT   = 5_000_000;

  // register indexes that the block decodes to nothing
  localparam logic [CfgIdxW-1:0] CfgSpareA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareB = CfgIdxW'(3);

  typedef logic [W-1:0] word_t;

  typedef enum logic {
    ROW_KEY,
    ROW_WORD
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  index;
    word_t               value;
    bit                  known;
    word_t               power;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  word_t              message;
  logic               out_valid;
  logic               out_stall;
  word_t              power_mod;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  word_t              cfg_data;

  plan_row_t   plan[$];
  word_t       pending_powers[$];
  word_t       key_exponent;
  word_t       key_modulus;
  word_t       expected_power;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned words_accepted;
  int unsigned words_returned;
  int unsigned fault_count;
  int unsigned key_writes;
  int unsigned cycle_count;
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned stall_mode;
  int unsigned stall_left;
  int unsigned stall_period;
  int unsigned stall_duty;
  int unsigned stall_phase;

  modular_exponentiation_top #(
    .WIDTH(W)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .message_i  (message),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .power_mod_o(power_mod),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  // message ** exponent mod modulus, right to left over every exponent bit
  function automatic word_t power_mod_of(word_t msg, word_t expo, word_t modulus);
    bit [63:0] acc;
    bit [63:0] base;
    bit [63:0] n;
    if (modulus < 2) return '0;
    n    = 64'(modulus);
    base = 64'(msg) % n;
    acc  = 64'd1;
    for (int b = 0; b < W; b++) begin
      if (expo[b]) acc = (acc * base) % n;
      base = (base * base) % n;
    end
    return acc[W-1:0];
  endfunction

  function automatic void key_row(logic [CfgIdxW-1:0] idx, word_t value);
    plan_row_t r;
    r.kind  = ROW_KEY;
    r.index = idx;
    r.value = value;
    r.known = 1'b0;
    r.power = '0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void word_row(word_t msg, bit known, word_t power);
    plan_row_t r;
    r.kind  = ROW_WORD;
    r.index = '0;
    r.value = msg;
    r.known = known;
    r.power = power;
    plan.insert(plan.size(), r);
  endfunction

  function automatic word_t random_message();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return key_modulus - 1'b1;
      3:       return key_modulus;
      4, 5:    return (key_modulus != 0) ? word_t'($urandom % key_modulus) : word_t'($urandom);
      default: return word_t'($urandom);
    endcase
  endfunction

  // offer one word in bursts with random gaps; hold it until taken
  task automatic push_word(input word_t msg, input bit known, input word_t power);
    if (gap_left != 0) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      repeat (gap_left) @(negedge clk);
      gap_left = 0;
    end
    in_valid  <= 1'b1;
    message   <= msg;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_powers.insert(pending_powers.size(),
                          known ? power : power_mod_of(msg, key_exponent, key_modulus));
    words_accepted++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap_left = 0;
        4, 5, 6:    gap_left = $urandom_range(1, 10);
        7, 8:       gap_left = $urandom_range(10, 300);
        default:    gap_left = $urandom_range(300, 2500);
      endcase
    end
    @(negedge clk);
  endtask

  // wait for every pending result so the block is idle for a key write
  task automatic drain_pipe();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending_powers.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_key(input logic [CfgIdxW-1:0] idx, input word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgExponent) key_exponent = value;
    else if (idx == CfgModulus) key_modulus = value;
    key_writes++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_powers.size());
      $display("modular_exponentiation_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_returned++;
      if (pending_powers.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unexpected word %h with nothing pending", power_mod);
      end else begin
        expected_power = pending_powers.pop_front();
        if (power_mod !== expected_power) begin
          fault_count++;
          if (fault_count <= 10)
            $display("power_mod mismatch on result %0d: expected %h, got %h",
                     words_returned, expected_power, power_mod);
        end
      end
    end
  end

  // output side: shifting stall patterns, plus two long hold-offs to back up the input
  initial begin
    out_stall  <= 1'b0;
    hold_left   = 0;
    holds_done  = 0;
    stall_left  = 0;
    stall_phase = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if ((holds_done == 0 && words_accepted >= 90) ||
                   (holds_done == 1 && words_accepted >= 200)) begin
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0) begin
          stall_mode   = $urandom_range(0, 3);
          stall_left   = (stall_mode == 3) ? $urandom_range(1, 300) : $urandom_range(20, 2000);
          stall_period = $urandom_range(2, 60);
          stall_duty   = $urandom_range(1, stall_period - 1);
          stall_phase  = 0;
        end
        stall_left--;
        stall_phase = (stall_phase + 1) % stall_period;
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 2) == 0);
          2:       out_stall <= (stall_phase < stall_duty);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    int unsigned directed_words;
    int unsigned random_words;
    int unsigned phase_words;
    int unsigned settings;
    bit          prev_key;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    message        <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CfgExponent;
    cfg_data       <= '0;
    key_exponent    = word_t'(ExponentReset);
    key_modulus     = word_t'(ModulusReset);
    burst_left      = $urandom_range(1, 8);
    gap_left        = 0;
    words_accepted  = 0;
    words_returned  = 0;
    fault_count     = 0;
    key_writes      = 0;
    cycle_count     = 0;
    random_words    = 0;
    settings        = 1;
    prev_key        = 1'b0;

    // after reset: exponent 17, modulus 2, so the parity of the word comes back
    word_row(32'h0000_0000, 1'b1, 32'h0000_0000);
    word_row(32'h0000_0001, 1'b1, 32'h0000_0001);
    word_row(32'hFFFF_FFFF, 1'b1, 32'h0000_0001);
    word_row(32'hFFFF_FFFE, 1'b1, 32'h0000_0000);
    // widest key: modulus equal to the word reduces it to zero, n-1 to an odd power stays n-1
    key_row(CfgModulus,  32'hFFFF_FFFF);
    key_row(CfgExponent, 32'hFFFF_FFFF);
    word_row(32'h0000_0000, 1'b1, 32'h0000_0000);
    word_row(32'h0000_0001, 1'b1, 32'h0000_0001);
    word_row(32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
    word_row(32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE);
    word_row(32'h1234_5678, 1'b0, '0);
    word_row(32'hA5A5_A5A5, 1'b0, '0);
    // zero exponent gives one, even for a zero word
    key_row(CfgExponent, 32'h0000_0000);
    word_row(32'h1234_5678, 1'b1, 32'h0000_0001);
    word_row(32'h0000_0000, 1'b1, 32'h0000_0001);
    // modulus below two gives zero
    key_row(CfgModulus, 32'h0000_0001);
    word_row(32'hDEAD_BEEF, 1'b1, 32'h0000_0000);
    key_row(CfgModulus, 32'h0000_0000);
    word_row(32'h0000_0005, 1'b1, 32'h0000_0000);
    // textbook key n = 61 * 53, e = 17, d = 2753
    key_row(CfgExponent, 32'd17);
    key_row(CfgModulus,  32'd3233);
    word_row(32'd65,   1'b1, 32'd2790);
    word_row(32'd3233, 1'b1, 32'd0);
    word_row(32'd3298, 1'b1, 32'd2790);
    key_row(CfgExponent, 32'd2753);
    word_row(32'd2790, 1'b1, 32'd65);
    // writes to undecoded indexes must leave the key alone
    key_row(CfgSpareA, 32'hFFFF_FFFF);
    key_row(CfgSpareB, 32'h0000_0000);
    word_row(32'd2790, 1'b1, 32'd65);
    key_row(CfgExponent, 32'd1);
    word_row(32'hFFFF_FFFF, 1'b0, '0);
    key_row(CfgExponent, 32'd2);
    key_row(CfgModulus,  32'h8000_0000);
    word_row(32'h7FFF_FFFF, 1'b0, '0);
    word_row(32'h5555_5555, 1'b0, '0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_KEY) begin
        if (!prev_key) begin
          drain_pipe();
          settings++;
        end
        write_key(plan[r].index, plan[r].value);
      end else begin
        push_word(plan[r].value, plan[r].known, plan[r].power);
      end
      prev_key = (plan[r].kind == ROW_KEY);
    end
    directed_words = words_accepted;

    while (random_words < RANDOM_WORDS) begin
      drain_pipe();
      settings++;
      case ($urandom_range(0, 7))
        0:       write_key(CfgExponent, '0);
        1:       write_key(CfgExponent, '1);
        2:       write_key(CfgExponent, 32'd65537);
        3:       write_key(CfgExponent, word_t'($urandom_range(1, 255)));
        default: write_key(CfgExponent, word_t'($urandom));
      endcase
      case ($urandom_range(0, 9))
        0:       write_key(CfgModulus, '1);
        1:       write_key(CfgModulus, 32'd2);
        2:       write_key(CfgModulus, word_t'($urandom_range(0, 1)));
        3:       write_key(CfgModulus, word_t'($urandom_range(3, 5000)));
        4:       write_key(CfgModulus, word_t'($urandom) | 32'h8000_0001);
        default: write_key(CfgModulus, word_t'($urandom));
      endcase
      if ($urandom_range(0, 5) == 0)
        write_key($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, word_t'($urandom));
      phase_words = $urandom_range(6, 30);
      for (int k = 0; k < phase_words; k++) begin
        push_word(random_message(), 1'b0, '0);
        random_words++;
      end
    end

    drain_pipe();
    // let any stray word show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d directed, %0d random), %0d key settings, %0d writes",
             words_accepted, directed_words, random_words, settings, key_writes);
    $display("%0d results checked, %0d output hold-offs, %0d faults",
             words_returned, holds_done, fault_count);
    if (fault_count == 0 && pending_powers.size() == 0) begin
      $display("modular_exponentiation_top regression: pass");
    end else begin
      $display("modular_exponentiation_top regression: fail");
    end
    $finish;
  end

endmodule

/* modular_exponentiation_top.f */
+incdir+src
src/mexp_pkg.sv
src/mexp_ctrl.sv
src/mexp_dp.sv
src/modular_exponentiation_top.sv
src/mexp_checker.sv
verif/tb.sv
